FILE: rtl/gcc_pkg.sv
// Shared widths, stage counts and payload types of the gradient corner color block.
`default_nettype none
package gcc_pkg;

    localparam int DIR_WIDTH    = 16;
    localparam int FRAC_BITS    = 18;

    localparam int NORM_TOP     = 29;
    localparam int NORM_W       = NORM_TOP + 1;
    localparam int MAG_W        = (DIR_WIDTH > NORM_W) ? DIR_WIDTH : NORM_W;
    localparam int DEN_W        = MAG_W + 1;
    localparam int NUM_W        = DEN_W + 1;
    localparam int SUM_W        = NUM_W + 2;
    localparam int LEAD_W       = $clog2(DIR_WIDTH);

    localparam int SQR_W        = 2 * NORM_W;
    localparam int RAD_W        = SQR_W + 2;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int SREM_W       = ROOT_W + 2;
    localparam int SQ_PER       = 2;
    localparam int SQ_STAGES    = (ROOT_W + SQ_PER - 1) / SQ_PER;

    localparam int Q_W          = FRAC_BITS + 1;
    localparam int DIV_PER      = 2;
    localparam int DIV_STAGES   = (FRAC_BITS + DIV_PER - 1) / DIV_PER;

    localparam int CH_W         = 16;
    localparam int DIFF_W       = CH_W + 1;
    localparam int P_W          = DIFF_W + Q_W + 1;
    localparam int ACC_W        = P_W + 1;

    localparam int FRONT_STAGES = 5 + SQ_STAGES;
    localparam int BACK_STAGES  = DIV_STAGES + 4;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    typedef struct packed {
        logic [7:0]           sr;
        logic [7:0]           sg;
        logic [7:0]           sb;
        logic [7:0]           sa;
        logic [7:0]           er;
        logic [7:0]           eg;
        logic [7:0]           eb;
        logic [7:0]           ea;
        logic [7:0]           op;
        logic [DIR_WIDTH-1:0] x;
        logic [DIR_WIDTH-1:0] y;
        logic                 comp;
    } req_t;

    typedef struct packed {
        logic [7:0]      sr;
        logic [7:0]      sg;
        logic [7:0]      sb;
        logic [7:0]      er;
        logic [7:0]      eg;
        logic [7:0]      eb;
        logic [CH_W-1:0] sa;
        logic [CH_W-1:0] ea;
    } color_t;

    typedef struct packed {
        color_t           col;
        logic             xneg;
        logic             yneg;
        logic             zero;
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic [DEN_W-1:0] den;
    } item_t;

    typedef struct packed {
        color_t           col;
        logic [1:0]       corner;
        logic             skip;
        logic             last;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] d;
    } cor_t;

endpackage
`default_nettype wire

FILE: rtl/gcc_front.sv
// Per-request pipeline: magnitudes, alpha scaling, normalization and square root.
`default_nettype none
module gcc_front import gcc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire req_t  req,
    output logic       item_valid,
    input  wire logic  item_ready,
    output item_t      item
);

    typedef struct packed {
        color_t               col;
        logic                 xneg;
        logic                 yneg;
        logic                 comp;
        logic                 zero;
        logic [DIR_WIDTH-1:0] ax;
        logic [DIR_WIDTH-1:0] ay;
    } pre_t;

    typedef struct packed {
        item_t             it;
        logic              comp;
        logic [RAD_W-1:0]  rad;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_in;
    logic [FRONT_STAGES:0]   en;

    pre_t                p1_reg, p1_next, p2_reg, p3_reg;
    logic [LEAD_W-1:0]   lead_reg, lead_next;
    logic [NORM_W-1:0]   nx_reg, ny_reg, nx_next, ny_next;
    item_t               it4_reg, it4_next;
    logic                comp4_reg;
    logic [SQR_W-1:0]    sqx_reg, sqy_reg;
    sq_t                 sq_reg [SQ_STAGES+1];
    sq_t                 sq0_next;

    logic [DIR_WIDTH-1:0]          ax_c, ay_c, m_c;
    logic [DIR_WIDTH+NORM_TOP-1:0] wx_c, wy_c;

    function automatic sq_t sq_step(sq_t a, int s);
        sq_t               r;
        logic [SREM_W+1:0] t;
        logic [SREM_W+1:0] trial;
        int                k;
        r = a;
        for (int j = 0; j < SQ_PER; j++)
        begin
            k = s * SQ_PER + j;
            if (k < ROOT_W)
            begin
                t     = {r.rem, r.rad[RAD_W-1 -: 2]};
                trial = {2'b00, r.root, 2'b01};
                if (t >= trial)
                begin
                    r.rem  = SREM_W'(t - trial);
                    r.root = {r.root[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    r.rem  = SREM_W'(t);
                    r.root = {r.root[ROOT_W-2:0], 1'b0};
                end
                r.rad = {r.rad[RAD_W-3:0], 2'b00};
            end
        end
        return r;
    endfunction

    always_comb
    begin
        en[FRONT_STAGES] = item_ready;
        for (int i = FRONT_STAGES - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign vld_in     = {vld_reg[FRONT_STAGES-2:0], in_valid};
    assign in_ready   = en[0];
    assign item_valid = vld_reg[FRONT_STAGES-1];

    always_comb
    begin
        ax_c = req.x[DIR_WIDTH-1] ? (~req.x + DIR_WIDTH'(1)) : req.x;
        ay_c = req.y[DIR_WIDTH-1] ? (~req.y + DIR_WIDTH'(1)) : req.y;
        p1_next.col.sr = req.sr;
        p1_next.col.sg = req.sg;
        p1_next.col.sb = req.sb;
        p1_next.col.er = req.er;
        p1_next.col.eg = req.eg;
        p1_next.col.eb = req.eb;
        p1_next.col.sa = CH_W'(req.sa) * CH_W'(req.op);
        p1_next.col.ea = CH_W'(req.ea) * CH_W'(req.op);
        p1_next.xneg   = req.x[DIR_WIDTH-1];
        p1_next.yneg   = req.y[DIR_WIDTH-1];
        p1_next.comp   = req.comp;
        p1_next.zero   = (ax_c == '0) && (ay_c == '0);
        p1_next.ax     = ax_c;
        p1_next.ay     = ay_c;
    end

    always_comb
    begin
        m_c       = (p1_reg.ax > p1_reg.ay) ? p1_reg.ax : p1_reg.ay;
        lead_next = '0;
        for (int i = 0; i < DIR_WIDTH; i++)
        begin
            if (m_c[i])
            begin
                lead_next = LEAD_W'(i);
            end
        end
    end

    always_comb
    begin
        wx_c    = {p2_reg.ax, {NORM_TOP{1'b0}}} >> lead_reg;
        wy_c    = {p2_reg.ay, {NORM_TOP{1'b0}}} >> lead_reg;
        nx_next = wx_c[NORM_W-1:0];
        ny_next = wy_c[NORM_W-1:0];
    end

    always_comb
    begin
        it4_next.col  = p3_reg.col;
        it4_next.xneg = p3_reg.xneg;
        it4_next.yneg = p3_reg.yneg;
        it4_next.zero = p3_reg.zero;
        it4_next.mx   = p3_reg.comp ? MAG_W'(p3_reg.ax) : MAG_W'(nx_reg);
        it4_next.my   = p3_reg.comp ? MAG_W'(p3_reg.ay) : MAG_W'(ny_reg);
        it4_next.den  = DEN_W'(p3_reg.ax) + DEN_W'(p3_reg.ay);
    end

    always_comb
    begin
        sq0_next.it   = it4_reg;
        sq0_next.comp = comp4_reg;
        sq0_next.rad  = {(SQR_W + 1)'(sqx_reg) + (SQR_W + 1)'(sqy_reg), 1'b0};
        sq0_next.rem  = '0;
        sq0_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < FRONT_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p1_reg <= p1_next;
        end
        if (en[1])
        begin
            p2_reg   <= p1_reg;
            lead_reg <= lead_next;
        end
        if (en[2])
        begin
            p3_reg <= p2_reg;
            nx_reg <= nx_next;
            ny_reg <= ny_next;
        end
        if (en[3])
        begin
            it4_reg   <= it4_next;
            comp4_reg <= p3_reg.comp;
            sqx_reg   <= SQR_W'(nx_reg) * SQR_W'(nx_reg);
            sqy_reg   <= SQR_W'(ny_reg) * SQR_W'(ny_reg);
        end
        if (en[4])
        begin
            sq_reg[0] <= sq0_next;
        end
        for (int s = 0; s < SQ_STAGES; s++)
        begin
            if (en[5+s])
            begin
                sq_reg[s+1] <= sq_step(sq_reg[s], s);
            end
        end
    end

    always_comb
    begin
        item     = sq_reg[SQ_STAGES].it;
        item.den = sq_reg[SQ_STAGES].comp ? sq_reg[SQ_STAGES].it.den
                                          : DEN_W'(sq_reg[SQ_STAGES].root);
    end

endmodule
`default_nettype wire

FILE: rtl/gcc_expand.sv
// Corner sequencer: holds one request and issues its corner items with clamped numerators.
`default_nettype none
module gcc_expand import gcc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire item_t item,
    output logic       cor_valid,
    input  wire logic  cor_ready,
    output cor_t       cor
);

    item_t      it_reg;
    logic       hv_reg;
    logic [1:0] k_reg;
    logic       last_c;

    logic signed [SUM_W-1:0] tx, ty, sum, top;

    assign last_c     = it_reg.zero || (k_reg == CORNER_LAST);
    assign item_ready = !hv_reg || (cor_ready && last_c);
    assign cor_valid  = hv_reg;

    always_comb
    begin
        tx  = (k_reg[0] ^ it_reg.xneg) ? -$signed(SUM_W'(it_reg.mx)) : $signed(SUM_W'(it_reg.mx));
        ty  = (k_reg[1] ^ it_reg.yneg) ? -$signed(SUM_W'(it_reg.my)) : $signed(SUM_W'(it_reg.my));
        top = $signed(SUM_W'({it_reg.den, 1'b0}));
        sum = $signed(SUM_W'(it_reg.den)) + tx + ty;
        if (sum < 0)
        begin
            sum = '0;
        end
        else if (sum > top)
        begin
            sum = top;
        end
        cor.col    = it_reg.col;
        cor.corner = it_reg.zero ? CORNER_FIRST : k_reg;
        cor.skip   = it_reg.zero;
        cor.last   = last_c;
        cor.num    = NUM_W'(sum);
        cor.d      = {it_reg.den, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= 1'b0;
            k_reg  <= CORNER_FIRST;
        end
        else if (item_valid && item_ready)
        begin
            hv_reg <= 1'b1;
            k_reg  <= CORNER_FIRST;
        end
        else if (hv_reg && cor_ready)
        begin
            if (last_c)
            begin
                hv_reg <= 1'b0;
            end
            else
            begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            it_reg <= item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/gcc_back.sv
// Per-corner pipeline: weight division, color blend, alpha divide and output register.
`default_nettype none
module gcc_back import gcc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cor_valid,
    output logic       cor_ready,
    input  wire cor_t  cor,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [1:0] corner,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha,
    output logic       skipped,
    output logic       last
);

    typedef struct packed {
        color_t     col;
        logic [1:0] corner;
        logic       skip;
        logic       last;
    } tag_t;

    typedef struct packed {
        tag_t                 tag;
        logic                 full;
        logic [NUM_W-1:0]     d;
        logic [NUM_W-1:0]     r;
        logic [FRAC_BITS-1:0] q;
    } dv_t;

    localparam int M1 = DIV_STAGES + 1;
    localparam int M2 = DIV_STAGES + 2;
    localparam int MO = DIV_STAGES + 3;

    logic [BACK_STAGES-1:0] vld_reg;
    logic [BACK_STAGES-1:0] vld_in;
    logic [BACK_STAGES:0]   en;

    dv_t                 dv_reg [DIV_STAGES+1];
    dv_t                 dv0_next;
    tag_t                m1_tag_reg, m2_tag_reg;
    logic signed [P_W-1:0] pr_reg, pg_reg, pb_reg, pa_reg;
    logic [CH_W-1:0]     vr_reg, vg_reg, vb_reg, va_reg;
    logic [Q_W-1:0]      w_c;
    logic [CH_W:0]       adiv_c;

    logic [1:0]          corner_reg;
    logic [7:0]          red_reg, green_reg, blue_reg, alpha_reg;
    logic                skip_reg, last_reg;

    function automatic dv_t dv_step(dv_t a, int s);
        dv_t            r;
        logic [NUM_W:0] t;
        int             k;
        r = a;
        for (int j = 0; j < DIV_PER; j++)
        begin
            k = s * DIV_PER + j;
            if (k < FRAC_BITS)
            begin
                t = {r.r, 1'b0};
                if (t >= {1'b0, r.d})
                begin
                    r.r = NUM_W'(t - {1'b0, r.d});
                    r.q = {r.q[FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    r.r = NUM_W'(t);
                    r.q = {r.q[FRAC_BITS-2:0], 1'b0};
                end
            end
        end
        return r;
    endfunction

    function automatic logic signed [P_W-1:0] blend_prod(logic [CH_W-1:0] s,
                                                         logic [CH_W-1:0] e,
                                                         logic [Q_W-1:0]  w);
        logic signed [DIFF_W-1:0] df;
        df = $signed({1'b0, s}) - $signed({1'b0, e});
        return df * $signed({1'b0, w});
    endfunction

    function automatic logic [CH_W-1:0] blend_sum(logic [CH_W-1:0] e,
                                                  logic signed [P_W-1:0] p);
        logic signed [ACC_W-1:0] acc;
        acc = $signed({{(ACC_W - CH_W - FRAC_BITS){1'b0}}, e, {FRAC_BITS{1'b0}}})
              + ACC_W'(p);
        return acc[FRAC_BITS +: CH_W];
    endfunction

    always_comb
    begin
        en[BACK_STAGES] = out_ready;
        for (int i = BACK_STAGES - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign vld_in    = {vld_reg[BACK_STAGES-2:0], cor_valid};
    assign cor_ready = en[0];
    assign out_valid = vld_reg[BACK_STAGES-1];

    always_comb
    begin
        dv0_next.tag.col    = cor.col;
        dv0_next.tag.corner = cor.corner;
        dv0_next.tag.skip   = cor.skip;
        dv0_next.tag.last   = cor.last;
        dv0_next.full       = cor.num >= cor.d;
        dv0_next.d          = cor.d;
        dv0_next.r          = (cor.num >= cor.d) ? '0 : cor.num;
        dv0_next.q          = '0;
    end

    assign w_c    = dv_reg[DIV_STAGES].full ? {1'b1, {FRAC_BITS{1'b0}}}
                                            : {1'b0, dv_reg[DIV_STAGES].q};
    assign adiv_c = (CH_W + 1)'(va_reg) + (CH_W + 1)'(va_reg >> 8) + (CH_W + 1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < BACK_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dv_reg[0] <= dv0_next;
        end
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (en[1+s])
            begin
                dv_reg[s+1] <= dv_step(dv_reg[s], s);
            end
        end
        if (en[M1])
        begin
            m1_tag_reg <= dv_reg[DIV_STAGES].tag;
            pr_reg <= blend_prod(CH_W'(dv_reg[DIV_STAGES].tag.col.sr),
                                 CH_W'(dv_reg[DIV_STAGES].tag.col.er), w_c);
            pg_reg <= blend_prod(CH_W'(dv_reg[DIV_STAGES].tag.col.sg),
                                 CH_W'(dv_reg[DIV_STAGES].tag.col.eg), w_c);
            pb_reg <= blend_prod(CH_W'(dv_reg[DIV_STAGES].tag.col.sb),
                                 CH_W'(dv_reg[DIV_STAGES].tag.col.eb), w_c);
            pa_reg <= blend_prod(dv_reg[DIV_STAGES].tag.col.sa,
                                 dv_reg[DIV_STAGES].tag.col.ea, w_c);
        end
        if (en[M2])
        begin
            m2_tag_reg <= m1_tag_reg;
            vr_reg <= blend_sum(CH_W'(m1_tag_reg.col.er), pr_reg);
            vg_reg <= blend_sum(CH_W'(m1_tag_reg.col.eg), pg_reg);
            vb_reg <= blend_sum(CH_W'(m1_tag_reg.col.eb), pb_reg);
            va_reg <= blend_sum(m1_tag_reg.col.ea, pa_reg);
        end
        if (en[MO])
        begin
            corner_reg <= m2_tag_reg.corner;
            skip_reg   <= m2_tag_reg.skip;
            last_reg   <= m2_tag_reg.last;
            red_reg    <= m2_tag_reg.skip ? 8'd0 : vr_reg[7:0];
            green_reg  <= m2_tag_reg.skip ? 8'd0 : vg_reg[7:0];
            blue_reg   <= m2_tag_reg.skip ? 8'd0 : vb_reg[7:0];
            alpha_reg  <= m2_tag_reg.skip ? 8'd0 : adiv_c[15:8];
        end
    end

    assign corner    = corner_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_alpha = alpha_reg;
    assign skipped   = skip_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

FILE: rtl/gradient_corner_colors_top.sv
// Top level of the linear gradient corner color block.
//
// Each accepted request yields four corner items (bottom-left, bottom-right,
// top-left, top-right), or a single item with skipped set for a zero direction
// vector; last marks the final item of a request. A request occupies the corner
// sequencer until its last item is taken, since every corner passes in turn
// through the one shared pipelined weight divider; the next request enters the
// sequencer as that last item leaves. The front pipeline normalizes the
// direction and runs a two-bit-per-stage square root, the back pipeline divides
// two quotient bits per stage and blends.
`default_nettype none
module gradient_corner_colors_top import gcc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           start_red,
    input  wire logic [7:0]           start_green,
    input  wire logic [7:0]           start_blue,
    input  wire logic [7:0]           start_alpha,
    input  wire logic [7:0]           end_red,
    input  wire logic [7:0]           end_green,
    input  wire logic [7:0]           end_blue,
    input  wire logic [7:0]           end_alpha,
    input  wire logic [7:0]           overall_opacity,
    input  wire logic [DIR_WIDTH-1:0] dir_x,
    input  wire logic [DIR_WIDTH-1:0] dir_y,
    input  wire logic                 compressed_mode,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                corner,
    output logic [7:0]                out_red,
    output logic [7:0]                out_green,
    output logic [7:0]                out_blue,
    output logic [7:0]                out_alpha,
    output logic                      skipped,
    output logic                      last
);

    req_t  req;
    item_t item;
    cor_t  cor;
    logic  item_valid, item_ready;
    logic  cor_valid, cor_ready;

    always_comb
    begin
        req.sr   = start_red;
        req.sg   = start_green;
        req.sb   = start_blue;
        req.sa   = start_alpha;
        req.er   = end_red;
        req.eg   = end_green;
        req.eb   = end_blue;
        req.ea   = end_alpha;
        req.op   = overall_opacity;
        req.x    = dir_x;
        req.y    = dir_y;
        req.comp = compressed_mode;
    end

    gcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req        (req),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    gcc_expand u_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cor_valid  (cor_valid),
        .cor_ready  (cor_ready),
        .cor        (cor)
    );

    gcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cor_valid (cor_valid),
        .cor_ready (cor_ready),
        .cor       (cor),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .corner    (corner),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha),
        .skipped   (skipped),
        .last      (last)
    );

endmodule
`default_nettype wire
